// ===== sv/qle_pkg.sv =====
// Shared types, constants and helper functions of the tabular Q-learning engine.
package qle_pkg;

  localparam int unsigned ROW_W     = 12;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned NUM_ACT   = 4;
  localparam int unsigned ADDR_W    = ROW_W + ACT_W;
  localparam int unsigned DEPTH     = 1 << ADDR_W;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned RATE_W    = 17;
  localparam int unsigned REWARD_W  = 24;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned REG_IDX_W = 1;
  localparam int unsigned DIFF_W    = VAL_W + 2;
  localparam int unsigned PROD_W    = RATE_W + 1 + DIFF_W;
  localparam int unsigned SUM_W     = PROD_W - FRAC_W + 1;

  localparam logic [RATE_W-1:0]       ONE_Q16        = RATE_W'(65536);
  localparam logic [RATE_W-1:0]       ALPHA_RESET    = RATE_W'(6554);
  localparam logic [RATE_W-1:0]       GAMMA_RESET    = RATE_W'(32768);
  localparam logic signed [VAL_W-1:0] MAX_FLOOR      = -32'sd655360000;
  localparam logic [PCT_W-1:0]        GREEDY_ALWAYS  = PCT_W'(100);

  localparam logic CMD_SELECT = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_LEARNING_RATE   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_DISCOUNT_FACTOR = 1'b1;

  typedef struct packed {
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [VAL_W-1:0]        wr_data;
  } mem_req_t;

  function automatic logic [ACT_W-1:0] explore_pick(input logic [ACT_W-1:0] ract,
                                                    input logic [NUM_ACT-1:0] mask);
    logic [ACT_W-1:0] pick;
    logic             hit;
    logic [ACT_W-1:0] c;
    pick = '0;
    hit  = 1'b0;
    for (int k = 0; k < NUM_ACT; k++) begin
      c = ract + ACT_W'(k);
      if (!hit && mask[c]) begin
        pick = c;
        hit  = 1'b1;
      end
    end
    return pick;
  endfunction

  function automatic logic [RATE_W-1:0] clamp_one(input logic [RATE_W-1:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

endpackage

// ===== sv/qle_if.sv =====
// Command and result channel interfaces of the tabular Q-learning engine.
interface qle_cmd_if;
  import qle_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [ROW_W-1:0]           state_index;
  logic [ROW_W-1:0]           next_state_index;
  logic [ACT_W-1:0]           action;
  logic signed [REWARD_W-1:0] reward;
  logic [NUM_ACT-1:0]         wall_mask;
  logic [PCT_W-1:0]           greedy_percent;
  logic [PCT_W-1:0]           random_draw;
  logic [ACT_W-1:0]           random_action;

  modport source (output valid, command, state_index, next_state_index, action, reward,
                  wall_mask, greedy_percent, random_draw, random_action, input ready);
  modport sink (input valid, command, state_index, next_state_index, action, reward,
                wall_mask, greedy_percent, random_draw, random_action, output ready);
endinterface

interface qle_res_if;
  import qle_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        chosen_action;
  logic                    was_greedy;
  logic signed [VAL_W-1:0] new_value;

  modport source (output valid, chosen_action, was_greedy, new_value, input ready);
  modport sink (input valid, chosen_action, was_greedy, new_value, output ready);
endinterface

// ===== sv/qle_qmem.sv =====
// Q table memory with one read and one write port and a clearing sweep after reset.
module qle_qmem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  qle_pkg::mem_req_t             req_i,
  output logic [qle_pkg::VAL_W-1:0]     rd_data_o,
  output logic                          busy_o
);
  import qle_pkg::*;

  logic [VAL_W-1:0]  mem [DEPTH];
  logic [VAL_W-1:0]  rd_data_q;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic              busy_q, busy_d;

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    busy_d    = busy_q;
    if (busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      busy_q    <= 1'b1;
    end else begin
      clr_cnt_q <= clr_cnt_d;
      busy_q    <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

// ===== sv/qle_mul.sv =====
// Shared registered multiplier of a Q1.16 rate by a signed difference.
module qle_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [qle_pkg::RATE_W-1:0]          a_i,
  input  logic signed [qle_pkg::DIFF_W-1:0]   b_i,
  output logic signed [qle_pkg::PROD_W-1:0]   p_o
);
  import qle_pkg::*;

  logic signed [PROD_W-1:0] p_q;
  logic signed [RATE_W:0]   a_s;

  assign a_s = $signed({1'b0, a_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_s * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// ===== sv/tabular_q_learning_engine.sv =====
// Top level of the tabular Q-learning engine: sequencer, registers and result stage.
//
//   channel  dir  handshake             payload
//   cmd_i    in   valid / ready         command, indexes, action, reward, mask, draws
//   res_o    out  valid / ready         chosen_action, was_greedy, new_value
//   cfg      in   cfg_we_i (no wait)    cfg_idx_i, cfg_wdata_i
//
// A select beat reads the four actions of its row in series through the single memory port;
// an update beat reads the four actions of the next row and then the current entry, and
// uses the shared multiplier twice. The next beat is taken only once the sequencer is idle.
// After reset all 16384 table entries are cleared, during which no beat is accepted.
// A result waiting on res_o does not block the next beat; that beat stalls only in its
// last step until the result stage is free.
module tabular_q_learning_engine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  qle_cmd_if.sink                         cmd_i,
  qle_res_if.source                       res_o,
  input  logic                            cfg_we_i,
  input  logic [qle_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  logic [qle_pkg::RATE_W-1:0]      cfg_wdata_i
);
  import qle_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_READ  = 8'b0000_0010,
    ST_DRAIN = 8'b0000_0100,
    ST_MUL1  = 8'b0000_1000,
    ST_TGT   = 8'b0001_0000,
    ST_MUL2  = 8'b0010_0000,
    ST_WB    = 8'b0100_0000,
    ST_SEL   = 8'b1000_0000
  } state_e;

  localparam logic [2:0] LAST_SEL = 3'd3;
  localparam logic [2:0] LAST_UPD = 3'd4;

  state_e                     state_q, state_d;
  logic [RATE_W-1:0]          alpha_q, gamma_q;
  logic                       cmd_q;
  logic [ROW_W-1:0]           row_q, nrow_q;
  logic [ACT_W-1:0]           act_q, ract_q;
  logic signed [REWARD_W-1:0] reward_q;
  logic [NUM_ACT-1:0]         mask_q;
  logic                       greedy_q;
  logic [2:0]                 cnt_q, cnt_d;
  logic                       rd_vld_q;
  logic [2:0]                 rd_tag_q;
  logic signed [VAL_W-1:0]    best_q, best_d, cur_q, cur_d;
  logic                       found_q, found_d;
  logic [ACT_W-1:0]           pick_q, pick_d;
  logic signed [DIFF_W-1:0]   diff_q;
  logic                       res_valid_q, res_valid_d;
  logic [ACT_W-1:0]           res_act_q;
  logic                       res_greedy_q;
  logic signed [VAL_W-1:0]    res_val_q;

  mem_req_t                   mem_req;
  logic [VAL_W-1:0]           rd_data;
  logic signed [VAL_W-1:0]    rd_val;
  logic                       clr_busy;
  logic                       accept, out_free, load_res, last_rd;
  logic [ROW_W-1:0]           rd_row;

  logic                       mul_en;
  logic [RATE_W-1:0]          mul_a;
  logic signed [DIFF_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-FRAC_W-1:0] prod_sh;
  logic signed [SUM_W-1:0]    upd;
  logic signed [VAL_W-1:0]    upd_sat;

  qle_qmem u_qmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data),
    .busy_o    (clr_busy)
  );

  qle_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign cmd_i.ready = (state_q == ST_IDLE) && !clr_busy;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign out_free    = !res_valid_q || res_o.ready;
  assign rd_val      = $signed(rd_data);
  assign last_rd     = (cnt_q == ((cmd_q == CMD_UPDATE) ? LAST_UPD : LAST_SEL));
  assign rd_row      = (cmd_q == CMD_UPDATE) ? nrow_q : row_q;
  assign prod_sh     = prod[PROD_W-1:FRAC_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RESET;
      gamma_q <= GAMMA_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEARNING_RATE:   alpha_q <= clamp_one(cfg_wdata_i);
        REG_DISCOUNT_FACTOR: gamma_q <= clamp_one(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    mem_req         = '0;
    mem_req.wr_addr = {row_q, act_q};
    mem_req.wr_data = upd_sat;
    if (state_q == ST_READ) begin
      mem_req.rd_en = 1'b1;
      if ((cmd_q == CMD_UPDATE) && (cnt_q == LAST_UPD)) begin
        mem_req.rd_addr = {row_q, act_q};
      end else begin
        mem_req.rd_addr = {rd_row, cnt_q[ACT_W-1:0]};
      end
    end
    mem_req.wr_en = (state_q == ST_WB) && out_free;
  end

  always_comb begin
    mul_en = 1'b0;
    mul_a  = gamma_q;
    mul_b  = DIFF_W'(best_q);
    if (state_q == ST_MUL1) begin
      mul_en = 1'b1;
    end else if (state_q == ST_MUL2) begin
      mul_en = 1'b1;
      mul_a  = alpha_q;
      mul_b  = diff_q;
    end
  end

  always_comb begin
    upd = SUM_W'(cur_q) + SUM_W'(prod_sh);
    if (upd > SUM_W'(32'sh7FFF_FFFF)) begin
      upd_sat = 32'sh7FFF_FFFF;
    end else if (upd < SUM_W'(32'sh8000_0000)) begin
      upd_sat = $signed(32'h8000_0000);
    end else begin
      upd_sat = upd[VAL_W-1:0];
    end
  end

  always_comb begin
    best_d  = best_q;
    cur_d   = cur_q;
    found_d = found_q;
    pick_d  = pick_q;
    if (accept) begin
      best_d  = (cmd_i.command == CMD_UPDATE) ? MAX_FLOOR : '0;
      found_d = 1'b0;
      pick_d  = '0;
    end else if (rd_vld_q) begin
      if (rd_tag_q == LAST_UPD) begin
        cur_d = rd_val;
      end else if (cmd_q == CMD_UPDATE) begin
        if (rd_val > best_q) begin
          best_d = rd_val;
        end
      end else if (mask_q[rd_tag_q[ACT_W-1:0]] && (!found_q || rd_val > best_q)) begin
        best_d  = rd_val;
        pick_d  = rd_tag_q[ACT_W-1:0];
        found_d = 1'b1;
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    load_res = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cnt_d = cnt_q + 1'b1;
        if (last_rd) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = (cmd_q == CMD_UPDATE) ? ST_MUL1 : ST_SEL;
      ST_MUL1:  state_d = ST_TGT;
      ST_TGT:   state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_WB;
      ST_WB, ST_SEL: begin
        if (out_free) begin
          load_res = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (load_res) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= (state_q == ST_READ);
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_tag_q <= cnt_q;
    best_q   <= best_d;
    cur_q    <= cur_d;
    found_q  <= found_d;
    pick_q   <= pick_d;
    if (accept) begin
      cmd_q    <= cmd_i.command;
      row_q    <= cmd_i.state_index;
      nrow_q   <= cmd_i.next_state_index;
      act_q    <= cmd_i.action;
      reward_q <= cmd_i.reward;
      mask_q   <= cmd_i.wall_mask;
      ract_q   <= cmd_i.random_action;
      greedy_q <= (cmd_i.random_draw <= cmd_i.greedy_percent) ||
                  (cmd_i.greedy_percent == GREEDY_ALWAYS);
    end
    if (state_q == ST_TGT) begin
      diff_q <= DIFF_W'(reward_q) + DIFF_W'(prod_sh) - DIFF_W'(cur_q);
    end
    if (load_res) begin
      if (cmd_q == CMD_UPDATE) begin
        res_act_q    <= '0;
        res_greedy_q <= 1'b0;
        res_val_q    <= upd_sat;
      end else begin
        res_act_q    <= greedy_q ? pick_q : explore_pick(ract_q, mask_q);
        res_greedy_q <= greedy_q;
        res_val_q    <= '0;
      end
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.chosen_action = res_act_q;
  assign res_o.was_greedy    = res_greedy_q;
  assign res_o.new_value     = res_val_q;

`ifndef SYNTH
  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !cmd_i.ready)
    else $error("Command beat could be accepted during the table clear.");

  a_read_data_in_read_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_READ || state_q == ST_DRAIN))
    else $error("Table read data arrived outside the read phase.");

  a_result_from_final_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(state_q == ST_WB || state_q == ST_SEL))
    else $error("Result beat appeared without a finishing step.");

  a_rates_at_most_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alpha_q <= ONE_Q16 && gamma_q <= ONE_Q16)
    else $error("Learning or discount rate register exceeds one.");

  a_write_only_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.wr_en |-> (cmd_q == CMD_UPDATE && !clr_busy))
    else $error("Table write outside an update step.");
`endif

endmodule

// ===== sim/qle_scoreboard.sv =====
// Scoreboard of the tabular Q-learning engine: watches the channels, predicts and compares.
module qle_scoreboard (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  qle_cmd_if                            cmd_i,
  qle_res_if                            res_i,
  input  logic                          cfg_we_i,
  input  logic [qle_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [qle_pkg::RATE_W-1:0]    cfg_wdata_i,
  output int unsigned                   err_count_o,
  output int unsigned                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import qle_pkg::*;

  typedef struct packed {
    logic [ACT_W-1:0]        act;
    logic                    greedy;
    logic signed [VAL_W-1:0] value;
  } outcome_t;

  logic signed [VAL_W-1:0] q_mirror [DEPTH];
  logic [RATE_W-1:0]       alpha_q;
  logic [RATE_W-1:0]       gamma_q;
  logic [RATE_W-1:0]       wdata_sat;
  outcome_t                outcome_q [$];
  outcome_t                want;

  function automatic outcome_t predict_outcome();
    outcome_t          o;
    longint            best;
    longint            cur;
    longint            target;
    longint            delta;
    longint            upd;
    longint            rew;
    longint            v;
    logic              found;
    logic [ADDR_W-1:0] addr;
    logic [ACT_W-1:0]  turn;
    o = '0;
    if (cmd_i.command == CMD_UPDATE) begin
      best = longint'(MAX_FLOOR);
      for (int i = 0; i < NUM_ACT; i++) begin
        v = q_mirror[{cmd_i.next_state_index, ACT_W'(i)}];
        if (v > best) begin
          best = v;
        end
      end
      addr   = {cmd_i.state_index, cmd_i.action};
      cur    = q_mirror[addr];
      rew    = cmd_i.reward;
      target = rew + ((longint'(gamma_q) * best) >>> FRAC_W);
      delta  = (longint'(alpha_q) * (target - cur)) >>> FRAC_W;
      upd    = cur + delta;
      if (upd > 64'sd2147483647) begin
        upd = 64'sd2147483647;
      end
      if (upd < -64'sd2147483648) begin
        upd = -64'sd2147483648;
      end
      q_mirror[addr] = upd[VAL_W-1:0];
      o.value        = upd[VAL_W-1:0];
    end else if (cmd_i.random_draw <= cmd_i.greedy_percent ||
                 cmd_i.greedy_percent == GREEDY_ALWAYS) begin
      o.greedy = 1'b1;
      found    = 1'b0;
      best     = 0;
      for (int i = 0; i < NUM_ACT; i++) begin
        if (cmd_i.wall_mask[i]) begin
          v = q_mirror[{cmd_i.state_index, ACT_W'(i)}];
          if (!found || v > best) begin
            best  = v;
            o.act = ACT_W'(i);
            found = 1'b1;
          end
        end
      end
    end else begin
      found = 1'b0;
      for (int k = 0; k < NUM_ACT; k++) begin
        turn = cmd_i.random_action + ACT_W'(k);
        if (!found && cmd_i.wall_mask[turn]) begin
          o.act = turn;
          found = 1'b1;
        end
      end
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (q_mirror[i]) q_mirror[i] = '0;
      alpha_q     = ALPHA_RESET;
      gamma_q     = GAMMA_RESET;
      outcome_q.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (outcome_q.size() == 0) begin
          err_count_o++;
          if (err_count_o <= 10) begin
            $display("%0t unexpected result beat: action %0d greedy %0d value %0d", $realtime,
                     res_i.chosen_action, res_i.was_greedy, res_i.new_value);
          end
        end else begin
          want = outcome_q.pop_front();
          if (res_i.chosen_action !== want.act || res_i.was_greedy !== want.greedy ||
              res_i.new_value !== want.value) begin
            err_count_o++;
            if (err_count_o <= 10) begin
              $display("%0t result mismatch: expected action %0d greedy %0d value %0d, got %s",
                       $realtime, want.act, want.greedy, want.value,
                       $sformatf("action %0d greedy %0d value %0d", res_i.chosen_action,
                                 res_i.was_greedy, res_i.new_value));
            end
          end
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        outcome_q.push_back(predict_outcome());
      end
      if (cfg_we_i) begin
        wdata_sat = (cfg_wdata_i > ONE_Q16) ? ONE_Q16 : cfg_wdata_i;
        if (cfg_idx_i == REG_LEARNING_RATE) begin
          alpha_q = wdata_sat;
        end else if (cfg_idx_i == REG_DISCOUNT_FACTOR) begin
          gamma_q = wdata_sat;
        end
      end
      pending_o = outcome_q.size();
    end
  end

endmodule

// ===== sim/tb_tabular_q_learning_engine.sv =====
// Testbench top of the tabular Q-learning engine: clock, reset, stimulus, back-pressure and verdict.
module tb_tabular_q_learning_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import qle_pkg::*;

  localparam int unsigned IDLE_LIMIT = 70000;
  localparam int unsigned POOL_SIZE  = 6;

  typedef struct packed {
    logic                command;
    logic [ROW_W-1:0]    state_index;
    logic [ROW_W-1:0]    next_state_index;
    logic [ACT_W-1:0]    action;
    logic [REWARD_W-1:0] reward;
    logic [NUM_ACT-1:0]  wall_mask;
    logic [PCT_W-1:0]    greedy_percent;
    logic [PCT_W-1:0]    random_draw;
    logic [ACT_W-1:0]    random_action;
  } cmd_beat_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx   = '0;
  logic [RATE_W-1:0]    cfg_wdata = '0;
  bit                   no_idle   = 1'b0;
  int unsigned          err_count;
  int unsigned          pending;
  int unsigned          idle_cycles = 0;
  logic [ROW_W-1:0]     row_pool [POOL_SIZE];

  qle_cmd_if cmd_bus ();
  qle_res_if res_bus ();

  always #1ns clk = ~clk;

  tabular_q_learning_engine u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cmd_i       (cmd_bus),
    .res_o       (res_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  qle_scoreboard u_scoreboard (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cmd_i       (cmd_bus),
    .res_i       (res_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  function automatic cmd_beat_t select_beat(input logic [ROW_W-1:0] row,
                                            input logic [NUM_ACT-1:0] mask,
                                            input logic [PCT_W-1:0] pct,
                                            input logic [PCT_W-1:0] draw,
                                            input logic [ACT_W-1:0] ract);
    cmd_beat_t b;
    b                = '0;
    b.command        = CMD_SELECT;
    b.state_index    = row;
    b.wall_mask      = mask;
    b.greedy_percent = pct;
    b.random_draw    = draw;
    b.random_action  = ract;
    return b;
  endfunction

  function automatic cmd_beat_t update_beat(input logic [ROW_W-1:0] row,
                                            input logic [ACT_W-1:0] act,
                                            input logic [ROW_W-1:0] nrow,
                                            input logic [REWARD_W-1:0] rew);
    cmd_beat_t b;
    b                  = '0;
    b.command          = CMD_UPDATE;
    b.state_index      = row;
    b.action           = act;
    b.next_state_index = nrow;
    b.reward           = rew;
    return b;
  endfunction

  // Most rows come from a small pool so that the table fills up and greedy picks differ.
  function automatic logic [ROW_W-1:0] pick_row();
    if ($urandom_range(0, 3) != 0) begin
      return row_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    return ROW_W'($urandom);
  endfunction

  function automatic cmd_beat_t random_beat();
    cmd_beat_t b;
    int        r;
    b.command          = $urandom_range(0, 1) ? CMD_UPDATE : CMD_SELECT;
    b.state_index      = pick_row();
    b.next_state_index = pick_row();
    b.action           = ACT_W'($urandom_range(0, 3));
    b.wall_mask        = NUM_ACT'($urandom);
    b.random_action    = ACT_W'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0: begin
        b.reward = REWARD_W'($urandom);
      end
      1: begin
        r        = int'($urandom_range(0, 524288)) - 262144;
        b.reward = r[REWARD_W-1:0];
      end
      2: begin
        b.reward = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      end
      default: begin
        r        = int'($urandom_range(0, 131072)) - 65536;
        b.reward = r[REWARD_W-1:0];
      end
    endcase
    case ($urandom_range(0, 9))
      0, 1: b.greedy_percent = GREEDY_ALWAYS;
      2: b.greedy_percent = PCT_W'($urandom_range(0, 127));
      default: b.greedy_percent = PCT_W'($urandom_range(0, 100));
    endcase
    if ($urandom_range(0, 9) == 0) begin
      b.random_draw = PCT_W'($urandom_range(0, 127));
    end else begin
      b.random_draw = PCT_W'($urandom_range(0, 99));
    end
    return b;
  endfunction

  task automatic send_beat(input cmd_beat_t b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_bus.valid            <= 1'b1;
    cmd_bus.command          <= b.command;
    cmd_bus.state_index      <= b.state_index;
    cmd_bus.next_state_index <= b.next_state_index;
    cmd_bus.action           <= b.action;
    cmd_bus.reward           <= b.reward;
    cmd_bus.wall_mask        <= b.wall_mask;
    cmd_bus.greedy_percent   <= b.greedy_percent;
    cmd_bus.random_draw      <= b.random_draw;
    cmd_bus.random_action    <= b.random_action;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    cmd_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic set_rates(input logic [RATE_W-1:0] alpha, input logic [RATE_W-1:0] gamma);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_LEARNING_RATE;
    cfg_wdata <= alpha;
    @(negedge clk);
    cfg_idx   <= REG_DISCOUNT_FACTOR;
    cfg_wdata <= gamma;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(input logic [RATE_W-1:0] alpha, input logic [RATE_W-1:0] gamma,
                              input int unsigned count, input bit burst);
    drain();
    set_rates(alpha, gamma);
    no_idle = burst;
    repeat (count) send_beat(random_beat());
    no_idle = 1'b0;
  endtask

  initial begin
    int unsigned hold;
    res_bus.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        res_bus.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      res_bus.ready <= 1'b1;
      @(posedge clk);
      while (!res_bus.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_tabular_q_learning_engine: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned      updates_sent;
    logic [ROW_W-1:0] ramp_row;
    cmd_bus.valid            = 1'b0;
    cmd_bus.command          = CMD_SELECT;
    cmd_bus.state_index      = '0;
    cmd_bus.next_state_index = '0;
    cmd_bus.action           = '0;
    cmd_bus.reward           = '0;
    cmd_bus.wall_mask        = '0;
    cmd_bus.greedy_percent   = '0;
    cmd_bus.random_draw      = '0;
    cmd_bus.random_action    = '0;
    row_pool[0] = '0;
    row_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) row_pool[i] = ROW_W'($urandom);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset rates: empty masks, extreme fields, draw at and beyond the percentage, ties.
    send_beat(select_beat(12'd0, 4'b0000, 7'd100, 7'd127, 2'd0));
    send_beat(select_beat(12'd0, 4'b0000, 7'd0, 7'd99, 2'd3));
    send_beat(update_beat(12'd0, 2'd0, 12'd4095, 24'h7FFFFF));
    send_beat(update_beat(12'd4095, 2'd3, 12'd0, 24'h800000));
    send_beat(update_beat(12'd0, 2'd2, 12'd0, 24'h000001));
    send_beat(update_beat(12'd0, 2'd1, 12'd0, 24'h7FFFFF));
    send_beat(select_beat(12'd0, 4'b1111, 7'd100, 7'd99, 2'd0));
    send_beat(select_beat(12'd0, 4'b1010, 7'd50, 7'd50, 2'd0));
    send_beat(select_beat(12'd0, 4'b0101, 7'd50, 7'd51, 2'd3));
    send_beat(select_beat(12'd4095, 4'b1000, 7'd127, 7'd127, 2'd0));
    send_beat(select_beat(12'd4095, 4'b0111, 7'd101, 7'd127, 2'd3));
    send_beat(select_beat(12'd1, 4'b1111, 7'd100, 7'd0, 2'd0));
    send_beat(select_beat(12'd1, 4'b0110, 7'd100, 7'd127, 2'd2));
    send_beat(select_beat(12'd1, 4'b1001, 7'd0, 7'd0, 2'd1));
    send_beat(select_beat(12'd1, 4'b1001, 7'd0, 7'd1, 2'd1));

    // A learning rate above one must act as one.
    drain();
    set_rates(17'h1FFFF, ONE_Q16);
    send_beat(update_beat(12'd2, 2'd1, 12'd2, 24'h7FFFFF));
    send_beat(update_beat(12'd2, 2'd1, 12'd2, 24'h7FFFFF));
    send_beat(select_beat(12'd2, 4'b1111, 7'd100, 7'd0, 2'd0));

    drain();
    set_rates('0, '0);
    send_beat(update_beat(12'd2, 2'd1, 12'd4095, 24'h800000));
    send_beat(update_beat(12'd4095, 2'd0, 12'd2, 24'h7FFFFF));
    send_beat(select_beat(12'd2, 4'b0010, 7'd100, 7'd100, 2'd0));

    random_phase(ONE_Q16, '0, 70, 1'b0);
    random_phase(RATE_W'($urandom_range(0, 65536)), RATE_W'($urandom_range(0, 65536)), 70, 1'b1);
    random_phase(RATE_W'(1), RATE_W'(65535), 70, 1'b0);
    random_phase(RATE_W'($urandom), RATE_W'($urandom), 70, 1'b0);

    // With both rates at one, self-loop updates with rewards at or near the largest drive a row into
    // positive saturation.
    drain();
    set_rates(ONE_Q16, 17'h1FFFF);
    ramp_row     = ROW_W'($urandom);
    updates_sent = 0;
    no_idle      = 1'b1;
    while (updates_sent < 270) begin
      if ($urandom_range(0, 7) == 0) begin
        send_beat(select_beat(ramp_row, NUM_ACT'($urandom), GREEDY_ALWAYS,
                              PCT_W'($urandom_range(0, 99)), ACT_W'($urandom)));
      end else begin
        send_beat(update_beat(ramp_row, ACT_W'($urandom), ramp_row,
                              REWARD_W'(24'h7FFFFF - $urandom_range(0, 7))));
        updates_sent++;
      end
      if (updates_sent >= 150) begin
        no_idle = 1'b0;
      end
    end
    no_idle = 1'b0;

    drain();
    if (err_count == 0) begin
      $display("tb_tabular_q_learning_engine: clean");
    end else begin
      $display("tb_tabular_q_learning_engine: errors");
    end
    $finish;
  end

endmodule

// ===== tabular_q_learning_engine.f =====
sv/qle_pkg.sv
sv/qle_if.sv
sv/qle_qmem.sv
sv/qle_mul.sv
sv/tabular_q_learning_engine.sv
sim/qle_scoreboard.sv
sim/tb_tabular_q_learning_engine.sv
